[sv/alpha_edge_pixel_blend_unit_macros.svh]
// ----------------------------------------------------------------------------
// alpha edge pixel blend unit: assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ALPHA_EDGE_PIXEL_BLEND_UNIT_MACROS_SVH
`define ALPHA_EDGE_PIXEL_BLEND_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AEPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aepb assertion failed");

// next-cycle implication
`define AEPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aepb assertion failed");

`else

`define AEPB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AEPB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/aepb_pkg.sv]
// ----------------------------------------------------------------------------
// aepb_pkg
// shared types, constants and pixel helpers of the alpha edge blend unit
// ----------------------------------------------------------------------------
package aepb_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned PixW    = 16;
  localparam int unsigned ChanW   = 5;
  localparam int unsigned RowLenW = 12;

  localparam logic [RowLenW-1:0] RowLenReset = 12'd160;
  localparam logic [WordW-1:0]   AlphaBoth   = 32'h0001_0001;

  // byte address of words_per_row on the register port
  localparam logic [1:0] RegRowLen = 2'd0;

  // colour of one pixel, alpha left out
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  function automatic rgb_t px_rgb(input logic [PixW-1:0] px);
    rgb_t c;
    c.r = px[15:11];
    c.g = px[10:6];
    c.b = px[5:1];
    return c;
  endfunction

  // floor average of two channel values
  function automatic logic [ChanW-1:0] chan_avg(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    logic [ChanW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ChanW:1];
  endfunction

  // blend a pixel with its predecessor when its alpha differs from the flag
  function automatic logic [PixW-1:0] blend_px(input logic [PixW-1:0] px,
                                               input rgb_t            prev,
                                               input logic            exp_alpha);
    rgb_t c;
    logic [PixW-1:0] res;
    c   = px_rgb(px);
    res = px;
    if (px[0] != exp_alpha) begin
      res = {chan_avg(c.r, prev.r), chan_avg(c.g, prev.g), chan_avg(c.b, prev.b), px[0]};
    end
    return res;
  endfunction

endpackage

[sv/aepb_in_if.sv]
// ----------------------------------------------------------------------------
// aepb_in_if
// input word channel: valid/ready with one pixel pair per beat
// ----------------------------------------------------------------------------
interface aepb_in_if import aepb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] pixel_pair;

  modport source (output valid, output pixel_pair, input ready);
  modport sink   (input valid, input pixel_pair, output ready);
endinterface

[sv/aepb_out_if.sv]
// ----------------------------------------------------------------------------
// aepb_out_if
// output word channel: valid/ready with one blended pixel pair per beat
// ----------------------------------------------------------------------------
interface aepb_out_if import aepb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] pixel_pair_out;

  modport source (output valid, output pixel_pair_out, input ready);
  modport sink   (input valid, input pixel_pair_out, output ready);
endinterface

[sv/alpha_edge_pixel_blend_unit.sv]
// ----------------------------------------------------------------------------
// alpha_edge_pixel_blend_unit
// smooths colour across alpha transitions in a stream of RGBA5551 pixel pairs
// ----------------------------------------------------------------------------
// The unit takes one 32-bit word (two RGBA5551 pixels, bits 31:16 first) per
// beat and returns one word per beat. Along a row it tracks an expected-alpha
// flag (starting at 1) and the previous pixel's original colour (starting at
// zero); a pixel whose alpha bit differs from the flag toggles the flag and
// gets each colour channel replaced by the floor average of its own and its
// predecessor's original value. Both alpha bits of every output word are set.
// After words_per_row words (APB register at byte 0, reset 160, 0 acts as 1)
// the row state starts over. Throughput is one word per clock while the output
// is not stalled: the row state register is updated from the word in the input
// register as that word advances, so consecutive words never wait on each
// other. Each word passes the input register, then the result register.
// A stalled output blocks input only once both registers hold a word.
// Write words_per_row only while the unit is idle; writes leave the row
// position untouched.
// ----------------------------------------------------------------------------
`include "alpha_edge_pixel_blend_unit_macros.svh"

module alpha_edge_pixel_blend_unit import aepb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  aepb_in_if.sink             pix_i,
  aepb_out_if.source          pix_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // config register
  logic [RowLenW-1:0] wpr_q;
  logic               cfg_wr;

  // input and result stages
  logic             in_vld_q;
  logic [WordW-1:0] in_data_q;
  logic             out_vld_q;
  logic [WordW-1:0] out_data_q;
  logic             advance;

  // row state
  logic               exp_q, exp_d;
  rgb_t               prev_q, prev_d;
  logic [RowLenW-1:0] col_q, col_d, col_inc;
  logic               row_end;

  // blend datapath
  logic [PixW-1:0]  px_hi, px_lo, res_hi, res_lo;
  logic [WordW-1:0] res_word;

  // apb: single register, every write lands on it, reads decode the address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == RegRowLen) ? {{(32-RowLenW){1'b0}}, wpr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpr_q <= RowLenReset;
    end else if (cfg_wr) begin
      wpr_q <= pwdata[RowLenW-1:0];
    end
  end

  // handshake: word moves to result stage when that stage is free or drains
  assign advance     = in_vld_q && (!out_vld_q || pix_o.ready);
  assign pix_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      in_data_q <= pix_i.pixel_pair;
    end
  end

  // blend: the upper pixel sees the row state, the lower pixel sees the
  // state left by the upper one (flag equals its alpha, prev its colour)
  assign px_hi    = in_data_q[WordW-1:PixW];
  assign px_lo    = in_data_q[PixW-1:0];
  assign res_hi   = blend_px(px_hi, prev_q, exp_q);
  assign res_lo   = blend_px(px_lo, px_rgb(px_hi), px_hi[0]);
  assign res_word = {res_hi, res_lo} | AlphaBoth;

  // row position, wraps at 12 bits like the counter it mirrors
  assign col_inc = col_q + 1'b1;
  assign row_end = (col_inc >= wpr_q) || (col_inc == '0);

  always_comb begin
    exp_d  = exp_q;
    prev_d = prev_q;
    col_d  = col_q;
    if (advance) begin
      if (row_end) begin
        exp_d  = 1'b1;
        prev_d = '0;
        col_d  = '0;
      end else begin
        exp_d  = px_lo[0];
        prev_d = px_rgb(px_lo);
        col_d  = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= 1'b1;
      prev_q <= '0;
      col_q  <= '0;
    end else begin
      exp_q  <= exp_d;
      prev_q <= prev_d;
      col_q  <= col_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res_word;
    end
  end

  assign pix_o.valid          = out_vld_q;
  assign pix_o.pixel_pair_out = out_data_q;

  // checks
  `AEPB_ASSERT_IMP(a_alpha_forced, clk_i, rst_ni, out_vld_q, out_data_q[PixW] && out_data_q[0])
  `AEPB_ASSERT_NXT(a_advance_fills, clk_i, rst_ni, advance, out_vld_q)
  `AEPB_ASSERT_NXT(a_row_restart, clk_i, rst_ni, advance && row_end, exp_q && col_q == '0 && prev_q == '0)

endmodule
